// ===== design/rgb_pixel_to_utf8_glyph_stream_macros.svh =====
// Assertion macros used by the glyph stream serializer.
`ifndef RGB_PIXEL_TO_UTF8_GLYPH_STREAM_MACROS_SVH
`define RGB_PIXEL_TO_UTF8_GLYPH_STREAM_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define RPU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpu assertion failed");

// Next-cycle implication, checked on clk and disabled during reset.
`define RPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpu assertion failed");

`endif

// ===== design/rpu_pkg.sv =====
// Package with widths, codes, types and helper functions of the glyph stream block.
`default_nettype none
package rpu_pkg;

  localparam int PALETTE_ENTRIES = 64;
  localparam int MAX_DIMENSION   = 4096;

  localparam int BYTE_W      = 8;
  localparam int GLYPH_BYTES = 4;
  localparam int GLYPH_W     = GLYPH_BYTES * BYTE_W;
  localparam int LEN_W       = 3;
  localparam int ENTRY_W     = GLYPH_W + LEN_W;
  localparam int BUCKET_W    = $clog2(PALETTE_ENTRIES);
  localparam int COLOR_W     = 8;
  localparam int DIM_W       = 13;
  localparam int CNT_W       = $clog2(MAX_DIMENSION);
  localparam int CFG_IDX_W   = 1;
  localparam int LUMA_SUM_W  = 16;

  // Luma weights and rounding term.
  localparam logic [LUMA_SUM_W-1:0] LUMA_R_K   = LUMA_SUM_W'(77);
  localparam logic [LUMA_SUM_W-1:0] LUMA_G_K   = LUMA_SUM_W'(150);
  localparam logic [LUMA_SUM_W-1:0] LUMA_B_K   = LUMA_SUM_W'(29);
  localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = LUMA_SUM_W'(128);

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [DIM_W-1:0]  MAX_DIM_V    = DIM_W'(MAX_DIMENSION);
  localparam logic [LEN_W-1:0]  MAX_LEN_V    = LEN_W'(GLYPH_BYTES);

  // Input operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  // Effective frame dimensions.
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  // Position of a pixel within its frame.
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } pos_t;

  // One pixel handed to the byte serializer.
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [LEN_W-1:0]   len;
    logic               newline;
    logic               frame_end;
  } ser_load_t;

  // Zero acts as one, values above the limit act as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > MAX_DIM_V) begin
      res = MAX_DIM_V;
    end
    return res;
  endfunction

  // Glyph lengths outside one to four snap to the nearest end.
  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > MAX_LEN_V) begin
      res = MAX_LEN_V;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/rpu_ifs.sv =====
// Channel interfaces for pixel input, text output and configuration writes.
`default_nettype none
interface rpu_pix_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [rpu_pkg::COLOR_W-1:0]     red;
  logic [rpu_pkg::COLOR_W-1:0]     green;
  logic [rpu_pkg::COLOR_W-1:0]     blue;
  logic [rpu_pkg::BUCKET_W-1:0]    entry_index;
  logic [rpu_pkg::GLYPH_W-1:0]     entry_bytes;
  logic [rpu_pkg::LEN_W-1:0]       entry_length;

  modport source (output valid, op, red, green, blue, entry_index, entry_bytes,
                  entry_length, input ready);
  modport sink (input valid, op, red, green, blue, entry_index, entry_bytes,
                entry_length, output ready);
endinterface

interface rpu_txt_if;
  logic                        valid;
  logic                        ready;
  logic [rpu_pkg::BYTE_W-1:0]  text_byte;
  logic                        pixel_done;
  logic                        frame_done;

  modport source (output valid, text_byte, pixel_done, frame_done, input ready);
  modport sink (input valid, text_byte, pixel_done, frame_done, output ready);
endinterface

interface rpu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rpu_pkg::CFG_IDX_W-1:0] index;
  logic [rpu_pkg::DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/rpu_palette_ram.sv =====
// Generic single-write, single-read synchronous RAM holding the glyph palette.
`default_nettype none
module rpu_palette_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 35
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/rpu_pixel_front.sv =====
// Luma bucket computation and row and column position tracking.
`default_nettype none
module rpu_pixel_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          pixel_take,
  input  wire logic [rpu_pkg::COLOR_W-1:0]   red,
  input  wire logic [rpu_pkg::COLOR_W-1:0]   green,
  input  wire logic [rpu_pkg::COLOR_W-1:0]   blue,
  input  wire rpu_pkg::dims_t                dims,
  output      logic [rpu_pkg::BUCKET_W-1:0]  bucket,
  output      rpu_pkg::pos_t                 pos
);

  logic [rpu_pkg::LUMA_SUM_W-1:0] luma_sum;
  logic [rpu_pkg::CNT_W-1:0]      col_r, col_nxt;
  logic [rpu_pkg::CNT_W-1:0]      row_r, row_nxt;

  // Weighted sum; its top six bits are the palette bucket.
  always_comb begin
    luma_sum = rpu_pkg::LUMA_R_K * rpu_pkg::LUMA_SUM_W'(red)
             + rpu_pkg::LUMA_G_K * rpu_pkg::LUMA_SUM_W'(green)
             + rpu_pkg::LUMA_B_K * rpu_pkg::LUMA_SUM_W'(blue)
             + rpu_pkg::LUMA_ROUND;
    bucket = luma_sum[rpu_pkg::LUMA_SUM_W-1 -: rpu_pkg::BUCKET_W];
  end

  // Row and frame ends of the pixel at the current position.
  always_comb begin
    pos.row_end   = (rpu_pkg::DIM_W'(col_r) + rpu_pkg::DIM_W'(1)) >= dims.width;
    pos.frame_end = pos.row_end
                  && ((rpu_pkg::DIM_W'(row_r) + rpu_pkg::DIM_W'(1)) >= dims.height);
  end

  // Advance the position on each pixel transfer.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (pixel_take) begin
      if (pos.frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (pos.row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/rpu_serializer.sv =====
// Byte serializer that emits a pixel's glyph bytes and an optional newline.
`default_nettype none
`include "rgb_pixel_to_utf8_glyph_stream_macros.svh"
module rpu_serializer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire rpu_pkg::ser_load_t load_data,
  output      logic               free,
  rpu_txt_if.source               out_ch
);

  logic [rpu_pkg::GLYPH_W-1:0] bytes_r, bytes_nxt;
  logic [rpu_pkg::LEN_W-1:0]   cnt_r, cnt_nxt;
  logic                        nl_r, nl_nxt;
  logic                        frame_r, frame_nxt;
  logic                        ser_v;
  logic                        is_last;
  logic                        xfer;
  logic                        done;

  // Current byte and its flags.
  always_comb begin
    ser_v   = (cnt_r != '0) || nl_r;
    is_last = ((cnt_r == rpu_pkg::LEN_W'(1)) && !nl_r) || (cnt_r == '0);
    xfer    = ser_v && out_ch.ready;
    done    = xfer && is_last;
    free    = !ser_v || done;

    out_ch.valid      = ser_v;
    out_ch.text_byte  = (cnt_r != '0) ? bytes_r[rpu_pkg::BYTE_W-1:0] : rpu_pkg::NEWLINE_BYTE;
    out_ch.pixel_done = is_last;
    out_ch.frame_done = is_last && frame_r;
  end

  // Take a new pixel or step to the next byte.
  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    nl_nxt    = nl_r;
    frame_nxt = frame_r;
    if (load) begin
      bytes_nxt = load_data.glyph;
      cnt_nxt   = rpu_pkg::clamp_len(load_data.len);
      nl_nxt    = load_data.newline;
      frame_nxt = load_data.frame_end;
    end else if (xfer) begin
      if (cnt_r != '0) begin
        bytes_nxt = {{rpu_pkg::BYTE_W{1'b0}}, bytes_r[rpu_pkg::GLYPH_W-1:rpu_pkg::BYTE_W]};
        cnt_nxt   = cnt_r - 1'b1;
      end else begin
        nl_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      nl_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      nl_r  <= nl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    frame_r <= frame_nxt;
  end

  // Remaining glyph bytes never exceed a full glyph.
  `RPU_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= rpu_pkg::MAX_LEN_V)
  // A new pixel only enters when the current one is gone or leaving.
  `RPU_ASSERT_IMPL(a_load_free, load, free)
  // The newline byte never closes a frame.
  `RPU_ASSERT_IMPL(a_nl_not_frame, (cnt_r == '0) && nl_r, !frame_r)
  // After the last byte leaves with nothing new, the serializer is empty.
  `RPU_ASSERT_NEXT(a_drain_empty, done && !load, !out_ch.valid)

endmodule
`default_nettype wire

// ===== design/rgb_pixel_to_utf8_glyph_stream.sv =====
// Top level: RGB pixels to a UTF-8 glyph byte stream through a palette RAM.
//
//  channel  | direction | transfer moves
//  ---------+-----------+-----------------------------------------------
//  in_ch    | sink      | one pixel or one palette entry load
//  out_ch   | source    | one text byte with pixel and frame end flags
//  cfg_ch   | sink      | one write of image width or image height
//
// A pixel yields its glyph length plus one newline byte at a row end that is not
// a frame end, 1 to 5 bytes in all, one byte per cycle from the serializer
// register while out_ch is ready. The first byte passes the palette RAM read
// register and then the serializer register, waiting while the serializer is busy.
// A load writes the palette RAM; no clearing pass follows reset.
// Input is taken while the serializer drains; a stalled output backs up one pixel.
`default_nettype none
module rgb_pixel_to_utf8_glyph_stream (
  input wire logic  clk,
  input wire logic  rst_n,
  rpu_pix_if.sink   in_ch,
  rpu_txt_if.source out_ch,
  rpu_cfg_if.sink   cfg_ch
);

  logic [rpu_pkg::DIM_W-1:0]    width_r;
  logic [rpu_pkg::DIM_W-1:0]    height_r;
  rpu_pkg::dims_t               dims;
  logic                         in_take;
  logic                         pixel_take;
  logic                         load_take;
  logic [rpu_pkg::BUCKET_W-1:0] bucket;
  rpu_pkg::pos_t                pos;
  rpu_pkg::pos_t                s2_pos_r;
  logic                         s2_v_r, s2_v_nxt;
  logic                         s2_move;
  logic                         ser_free;
  logic [rpu_pkg::ENTRY_W-1:0]  rd_entry;
  rpu_pkg::ser_load_t           ser_load;

  // Configuration registers; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rpu_pkg::DIM_W'(1);
      height_r <= rpu_pkg::DIM_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rpu_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_ch.data;
        rpu_pkg::CFG_IDX_HEIGHT: height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign dims.width  = rpu_pkg::eff_dim(width_r);
  assign dims.height = rpu_pkg::eff_dim(height_r);

  // Input handshake: the read stage must be empty or moving on.
  always_comb begin
    s2_move     = s2_v_r && ser_free;
    in_ch.ready = !s2_v_r || s2_move;
    in_take     = in_ch.valid && in_ch.ready;
    pixel_take  = in_take && (in_ch.op == rpu_pkg::OP_PIXEL);
    load_take   = in_take && (in_ch.op == rpu_pkg::OP_LOAD);
  end

  rpu_pixel_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .pixel_take (pixel_take),
    .red        (in_ch.red),
    .green      (in_ch.green),
    .blue       (in_ch.blue),
    .dims       (dims),
    .bucket     (bucket),
    .pos        (pos)
  );

  rpu_palette_ram #(
    .DEPTH (rpu_pkg::PALETTE_ENTRIES),
    .WIDTH (rpu_pkg::ENTRY_W)
  ) u_palette (
    .clk   (clk),
    .we    (load_take),
    .waddr (in_ch.entry_index),
    .wdata ({in_ch.entry_length, in_ch.entry_bytes}),
    .re    (pixel_take),
    .raddr (bucket),
    .rdata (rd_entry)
  );

  // Read stage: one pixel waits here for its palette entry.
  always_comb begin
    s2_v_nxt = s2_v_r;
    if (pixel_take) begin
      s2_v_nxt = 1'b1;
    end else if (s2_move) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      s2_pos_r <= pos;
    end
  end

  // Hand the glyph and its row flags to the serializer.
  always_comb begin
    ser_load.glyph     = rd_entry[rpu_pkg::GLYPH_W-1:0];
    ser_load.len       = rd_entry[rpu_pkg::ENTRY_W-1:rpu_pkg::GLYPH_W];
    ser_load.newline   = s2_pos_r.row_end && !s2_pos_r.frame_end;
    ser_load.frame_end = s2_pos_r.frame_end;
  end

  rpu_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s2_move),
    .load_data (ser_load),
    .free      (ser_free),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== verif/rgb_pixel_to_utf8_glyph_stream_tb.sv =====
// Self-checking testbench for the RGB pixel to UTF-8 glyph stream block.
`default_nettype none
module rgb_pixel_to_utf8_glyph_stream_tb;
  import rpu_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX    = 10;
  localparam int PHASES        = 9;

  // One item waiting to go into the block, plus a flag that holds it back
  // until the output side has drained.
  typedef struct {
    logic                wait_drain;
    logic                op;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [BUCKET_W-1:0] entry_index;
    logic [GLYPH_W-1:0]  entry_bytes;
    logic [LEN_W-1:0]    entry_length;
  } pixel_item_t;

  // One text byte as it should leave the block.
  typedef struct {
    logic [BYTE_W-1:0] text_byte;
    logic              pixel_done;
    logic              frame_done;
  } text_rec_t;

  logic clk;
  logic rst_n;

  rpu_pix_if in_ch ();
  rpu_txt_if out_ch ();
  rpu_cfg_if cfg_ch ();

  rgb_pixel_to_utf8_glyph_stream uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the palette, the raster position and the frame size.
  logic [GLYPH_W-1:0] glyph_mem [PALETTE_ENTRIES];
  int                 glyph_len_mem [PALETTE_ENTRIES];
  int                 col_pos;
  int                 row_pos;
  logic [DIM_W-1:0]   img_width;
  logic [DIM_W-1:0]   img_height;

  pixel_item_t pending_items [$];
  text_rec_t   expected_text [$];
  pixel_item_t in_flight;

  logic calm;
  int   cycle_count;
  int   error_count;
  int   pixels_taken;
  int   loads_taken;
  int   bytes_seen;
  int   frames_seen;

  always #10 clk = ~clk;

  // Report a failure; only the first few are printed in full.
  function automatic void log_mismatch(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) begin
      $display("[%0d] MISMATCH: %s", cycle_count, msg);
    end
  endfunction

  // Zero acts as one and anything beyond the largest frame acts as the largest.
  function automatic int clip_dim(input logic [DIM_W-1:0] v);
    int res;
    res = int'(v);
    if (res == 0) begin
      res = 1;
    end else if (res > MAX_DIMENSION) begin
      res = MAX_DIMENSION;
    end
    return res;
  endfunction

  // Work out the bytes that one accepted item causes and update the shadow state.
  function automatic void predict_text(input pixel_item_t it);
    int               luma;
    int               bucket;
    int               glen;
    bit               row_end;
    bit               frame_end;
    logic [GLYPH_W-1:0] glyph;
    text_rec_t        rec;
    if (it.op == OP_LOAD) begin
      glen = int'(it.entry_length);
      if (glen == 0) begin
        glen = 1;
      end else if (glen > GLYPH_BYTES) begin
        glen = GLYPH_BYTES;
      end
      glyph_mem[it.entry_index] = it.entry_bytes;
      glyph_len_mem[it.entry_index] = glen;
      loads_taken++;
    end else begin
      luma = (int'(LUMA_R_K) * int'(it.red) + int'(LUMA_G_K) * int'(it.green)
              + int'(LUMA_B_K) * int'(it.blue) + int'(LUMA_ROUND)) >> 8;
      bucket = (luma >> 2) % PALETTE_ENTRIES;
      glyph = glyph_mem[bucket];
      glen = glyph_len_mem[bucket];
      row_end = (col_pos + 1 >= clip_dim(img_width));
      frame_end = row_end && (row_pos + 1 >= clip_dim(img_height));
      for (int i = 0; i < glen; i++) begin
        rec.text_byte = glyph[8*i +: 8];
        rec.pixel_done = (i + 1 == glen) && (!row_end || frame_end);
        rec.frame_done = (i + 1 == glen) && frame_end;
        expected_text.push_back(rec);
      end
      if (row_end && !frame_end) begin
        rec.text_byte = NEWLINE_BYTE;
        rec.pixel_done = 1'b1;
        rec.frame_done = 1'b0;
        expected_text.push_back(rec);
      end
      if (frame_end) begin
        col_pos = 0;
        row_pos = 0;
      end else if (row_end) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
      pixels_taken++;
    end
  endfunction

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still expected", cycle_count,
               expected_text.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Input driver: predicts each transfer as it happens and presents the next item.
  always @(posedge clk) begin : pixel_driver
    logic took;
    logic hold_off;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        predict_text(in_flight);
      end
      if (took || !in_ch.valid) begin
        hold_off = (pending_items.size() == 0) || (!calm && $urandom_range(0, 99) < 10);
        if (!hold_off && pending_items[0].wait_drain && expected_text.size() != 0) begin
          hold_off = 1'b1;
        end
        if (hold_off) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_flight = pending_items.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.op           <= in_flight.op;
          in_ch.red          <= in_flight.red;
          in_ch.green        <= in_flight.green;
          in_ch.blue         <= in_flight.blue;
          in_ch.entry_index  <= in_flight.entry_index;
          in_ch.entry_bytes  <= in_flight.entry_bytes;
          in_ch.entry_length <= in_flight.entry_length;
        end
      end
    end
  end

  // Output monitor: checks each byte transfer against the oldest expectation.
  always @(posedge clk) begin : text_monitor
    text_rec_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        bytes_seen++;
        if (out_ch.frame_done === 1'b1) begin
          frames_seen++;
        end
        if (expected_text.size() == 0) begin
          log_mismatch($sformatf("unexpected byte %02h pixel_done=%b frame_done=%b",
                                 out_ch.text_byte, out_ch.pixel_done, out_ch.frame_done));
        end else begin
          want = expected_text.pop_front();
          if (out_ch.text_byte !== want.text_byte || out_ch.pixel_done !== want.pixel_done
              || out_ch.frame_done !== want.frame_done) begin
            log_mismatch($sformatf(
              "byte %0d: expected %02h/%b/%b, got %02h/%b/%b", bytes_seen,
              want.text_byte, want.pixel_done, want.frame_done,
              out_ch.text_byte, out_ch.pixel_done, out_ch.frame_done));
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // Queue one item as given; the wrappers below put random filler in the fields that its operation ignores.
  task automatic queue_item(input logic op, input logic [COLOR_W-1:0] r,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b,
                            input logic [BUCKET_W-1:0] idx, input logic [GLYPH_W-1:0] bytes,
                            input logic [LEN_W-1:0] len, input logic drain);
    pixel_item_t it;
    it.wait_drain   = drain;
    it.op           = op;
    it.red          = r;
    it.green        = g;
    it.blue         = b;
    it.entry_index  = idx;
    it.entry_bytes  = bytes;
    it.entry_length = len;
    pending_items.push_back(it);
  endtask

  task automatic queue_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                             input logic [COLOR_W-1:0] b);
    queue_item(OP_PIXEL, r, g, b, BUCKET_W'($urandom), $urandom, LEN_W'($urandom), 1'b0);
  endtask

  task automatic queue_load(input logic [BUCKET_W-1:0] idx, input logic [GLYPH_W-1:0] bytes,
                            input logic [LEN_W-1:0] len);
    queue_item(OP_LOAD, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
               idx, bytes, len, 1'b0);
  endtask

  // Mostly pixels, both colorful and gray, with palette reloads mixed in.
  task automatic queue_random(input int count);
    logic [COLOR_W-1:0] gray;
    logic               drain;
    for (int k = 0; k < count; k++) begin
      drain = (k == count / 2) || ($urandom_range(0, 99) < 3);
      gray = COLOR_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 15) begin
        queue_item(OP_LOAD, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                   BUCKET_W'($urandom), $urandom, LEN_W'($urandom_range(0, 7)), drain);
      end else if ($urandom_range(0, 99) < 30) begin
        queue_item(OP_PIXEL, gray, gray, gray, BUCKET_W'($urandom), $urandom,
                   LEN_W'($urandom), drain);
      end else begin
        queue_item(OP_PIXEL, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                   BUCKET_W'($urandom), $urandom, LEN_W'($urandom), drain);
      end
    end
  endtask

  // Wait until every item is in and every byte is out, then let a load finish.
  // The check runs at the falling edge so that the driver's updates have settled.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || in_ch.valid || expected_text.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write over the configuration channel.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    if (idx == CFG_IDX_WIDTH) begin
      img_width = value;
    end else begin
      img_height = value;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    wait_idle();
    write_reg(CFG_IDX_WIDTH, w);
    write_reg(CFG_IDX_HEIGHT, h);
  endtask

  // Random phases: frame sizes include the largest frame and values past it.
  int   phase_w [PHASES] = '{4, 8191, 5, 1, 4096, 2, 7, 3, 6};
  int   phase_h [PHASES] = '{3, 2, 1, 6, 4096, 8191, 5, 4, 2};
  int   phase_n [PHASES] = '{40, 35, 40, 40, 35, 35, 40, 40, 48};
  logic phase_calm [PHASES] = '{0, 0, 0, 0, 0, 1, 0, 0, 0};

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    calm = 1'b0;
    cycle_count = 0;
    error_count = 0;
    pixels_taken = 0;
    loads_taken = 0;
    bytes_seen = 0;
    frames_seen = 0;
    col_pos = 0;
    row_pos = 0;
    img_width = DIM_W'(1);
    img_height = DIM_W'(1);
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    in_ch.entry_index = '0;
    in_ch.entry_bytes = '0;
    in_ch.entry_length = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_IDX_WIDTH;
    cfg_ch.data = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole palette so that no pixel ever reads an empty entry.
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      queue_load(BUCKET_W'(i), $urandom, LEN_W'(i % GLYPH_BYTES + 1));
    end

    // Single pixel frames at the reset size: black and white.
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);

    // Three by two frame: length clamping on reload, primaries, newlines.
    set_frame(DIM_W'(3), DIM_W'(2));
    queue_load(BUCKET_W'(0), 32'h11223344, LEN_W'(0));
    queue_load(BUCKET_W'(63), 32'hA5C3E1F0, LEN_W'(7));
    queue_load(BUCKET_W'(19), 32'h0A0B0C0D, LEN_W'(5));
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'hFF, 8'h00, 8'h00);
    queue_pixel(8'h00, 8'hFF, 8'h00);
    queue_pixel(8'h00, 8'h00, 8'hFF);
    queue_pixel(8'hFF, 8'hFF, 8'h00);

    // Zero width and height behave as a one pixel frame.
    set_frame(DIM_W'(0), DIM_W'(0));
    queue_pixel(8'h80, 8'h80, 8'h80);
    queue_pixel(8'h01, 8'h02, 8'h03);

    // Random phases; the raster position carries over each size change.
    for (int p = 0; p < PHASES; p++) begin
      set_frame(DIM_W'(phase_w[p]), DIM_W'(phase_h[p]));
      calm = phase_calm[p];
      queue_random(phase_n[p]);
    end

    wait_idle();
    calm = 1'b0;
    if (expected_text.size() != 0) begin
      log_mismatch($sformatf("%0d bytes never arrived", expected_text.size()));
    end

    $display("Run covered %0d pixels and %0d palette loads over %0d frame sizes,",
             pixels_taken, loads_taken, PHASES + 3);
    $display("checking %0d text bytes and %0d frame ends; %0d mismatches.",
             bytes_seen, frames_seen, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/rpu_pkg.sv
design/rpu_ifs.sv
design/rpu_palette_ram.sv
design/rpu_pixel_front.sv
design/rpu_serializer.sv
design/rgb_pixel_to_utf8_glyph_stream.sv
verif/rgb_pixel_to_utf8_glyph_stream_tb.sv
